// ===== rtl/tsxb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsxb_pkg;

    // Operation codes carried in the op field of an input transfer
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

endpackage : tsxb_pkg

`default_nettype wire

// ===== rtl/tsxb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: insert or query item
interface tsxb_in_if #(
    parameter int WORD_BITS  = 20,
    parameter int INDEX_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [WORD_BITS-1:0]  value;
    logic [INDEX_BITS-1:0] item_index;
    logic [INDEX_BITS-1:0] lower_index;

    modport source (output valid, op, value, item_index, lower_index, input ready);
    modport sink   (input valid, op, value, item_index, lower_index, output ready);
endinterface : tsxb_in_if

// Output channel: query result
interface tsxb_out_if #(
    parameter int WORD_BITS = 20
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] max_xor;

    modport source (output valid, max_xor, input ready);
    modport sink   (input valid, max_xor, output ready);
endinterface : tsxb_out_if

`default_nettype wire

// ===== rtl/tsxb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Generic single write port, single read port RAM with registered read
module tsxb_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 20
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : tsxb_ram

`default_nettype wire

// ===== rtl/timestamped_xor_basis.sv =====
// Processing: a transfer is walked one basis slot per cycle, top bit down through the
//   slot RAM; a query result is then offered in the output register.
// Items: a new item is accepted only once the last one is through the walk; a result
//   still waiting in the output register holds a finished query in S_HOLD meanwhile.
// Reset: synchronous, active low; clears the per-slot valid flags at once, so the
//   basis is empty after reset. No clearing pass over the RAM.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_xor_basis
    import tsxb_pkg::*;
#(
    parameter int WORD_BITS  = 20,
    parameter int INDEX_BITS = 20
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsxb_in_if.sink     i_in,
    tsxb_out_if.source  o_out
);

    localparam int AW = $clog2(WORD_BITS);
    localparam int DW = WORD_BITS + INDEX_BITS;
    localparam logic [AW-1:0] TOP = AW'(WORD_BITS - 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_HOLD} t_state;

    t_state                r_state;
    logic [AW-1:0]         r_bit;
    logic                  r_op;
    logic [WORD_BITS-1:0]  r_word;     // carried word on insert, accumulator on query
    logic [INDEX_BITS-1:0] r_tag;      // carried tag on insert, lower bound on query
    logic [WORD_BITS-1:0]  r_valid;    // slot holds a nonzero word
    logic                  r_out_valid;
    logic [WORD_BITS-1:0]  r_out_data;

    logic [WORD_BITS-1:0]  n_word;
    logic [INDEX_BITS-1:0] n_tag;
    logic                  n_set_valid;
    logic                  we;
    logic [AW-1:0]         raddr;
    logic [DW-1:0]         rdata;
    logic [WORD_BITS-1:0]  slot_word;
    logic [INDEX_BITS-1:0] slot_tag;
    logic                  slot_full;
    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  last_bit;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign last_bit = (r_bit == '0);

    // Output register takes a query result at the end of the walk or from hold
    assign out_load = out_free &&
                      ((r_state == S_WALK && last_bit && r_op == OP_QUERY) ||
                       r_state == S_HOLD);

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.max_xor = r_out_data;

    // Read the top slot at accept, then the next lower slot while processing one
    assign raddr = (r_state == S_WALK && !last_bit) ? r_bit - AW'(1) : TOP;

    tsxb_ram #(
        .WIDTH (DW),
        .DEPTH (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_bit),
        .i_wdata ({r_tag, r_word}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign slot_word = rdata[WORD_BITS-1:0];
    assign slot_tag  = rdata[DW-1:WORD_BITS];
    assign slot_full = r_valid[r_bit];

    // One slot step of insert or query
    always_comb begin
        n_word      = r_word;
        n_tag       = r_tag;
        n_set_valid = 1'b0;
        we          = 1'b0;
        if (r_state == S_WALK) begin
            if (r_op == OP_INSERT) begin
                if (r_word[r_bit]) begin
                    if (!slot_full) begin
                        // empty slot: store and stop carrying
                        we          = 1'b1;
                        n_set_valid = 1'b1;
                        n_word      = '0;
                    end else if (r_tag > slot_tag) begin
                        // newer item takes the slot, old word reduces on
                        we     = 1'b1;
                        n_word = r_word ^ slot_word;
                        n_tag  = slot_tag;
                    end else begin
                        n_word = r_word ^ slot_word;
                    end
                end
            end else begin
                if (slot_full && slot_tag >= r_tag && !r_word[r_bit]) begin
                    n_word = r_word ^ slot_word;
                end
            end
        end
    end

    // Sequencer, slot flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_WALK;
                        r_bit   <= TOP;
                        r_op    <= i_in.op;
                        if (i_in.op == OP_INSERT) begin
                            r_word <= i_in.value;
                            r_tag  <= i_in.item_index;
                        end else begin
                            r_word <= '0;
                            r_tag  <= i_in.lower_index;
                        end
                    end
                end
                S_WALK: begin
                    r_word <= n_word;
                    r_tag  <= n_tag;
                    if (n_set_valid) begin
                        r_valid[r_bit] <= 1'b1;
                    end
                    if (last_bit) begin
                        if (r_op == OP_QUERY && !out_free) begin
                            r_state <= S_HOLD;
                        end else begin
                            r_state <= S_IDLE;
                            if (r_op == OP_QUERY) begin
                                r_out_data <= n_word;
                            end
                        end
                    end else begin
                        r_bit <= r_bit - AW'(1);
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_out_data <= r_word;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule : timestamped_xor_basis

`default_nettype wire

// ===== rtl/tsxb_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsxb_check
    import tsxb_pkg::*;
#(
    parameter int WORD_BITS = 20
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_in_op,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [WORD_BITS-1:0] i_out_data
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

    // One item at a time: the input closes after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input open right after a transfer");

    // An insert never produces a result
    a_insert_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == OP_INSERT && !i_out_valid
        |=> !i_out_valid)
        else $error("result appeared after an insert");

endmodule : tsxb_check

bind timestamped_xor_basis tsxb_check #(
    .WORD_BITS (WORD_BITS)
) u_tsxb_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.max_xor)
);

`default_nettype wire

// ===== bench/timestamped_xor_basis_test.sv =====
`timescale 1ns / 1ps

module timestamped_xor_basis_test;
    import tsxb_pkg::*;

    localparam int WORD_W     = 20;
    localparam int TAG_W      = 20;
    localparam int ITEM_CYC   = WORD_W + 1;
    localparam int QUIET_MAX  = 3000;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_ITEMS = 530;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [TAG_W-1:0]  tag_t;

    // Model of the recency-preferring basis plus the queue of query answers
    class xor_basis_scoreboard;
        word_t       slot_word [WORD_W];
        tag_t        slot_tag  [WORD_W];
        word_t       pending_max_xor [$];
        int unsigned errors;

        function new();
            foreach (slot_word[b]) begin
                slot_word[b] = '0;
                slot_tag[b]  = '0;
            end
            errors = 0;
        endfunction

        // Top-down reduction; a newer tag takes over the slot and the old
        // word is carried on instead
        function void insert_word(word_t word, tag_t tag);
            word_t carry_word;
            tag_t  carry_tag;
            word_t swap_word;
            tag_t  swap_tag;
            carry_word = word;
            carry_tag  = tag;
            for (int b = WORD_W - 1; b >= 0; b--) begin
                if (carry_word[b]) begin
                    if (slot_word[b] == '0) begin
                        slot_word[b] = carry_word;
                        slot_tag[b]  = carry_tag;
                        return;
                    end
                    if (carry_tag > slot_tag[b]) begin
                        swap_word    = slot_word[b];
                        swap_tag     = slot_tag[b];
                        slot_word[b] = carry_word;
                        slot_tag[b]  = carry_tag;
                        carry_word   = swap_word;
                        carry_tag    = swap_tag;
                    end
                    carry_word = carry_word ^ slot_word[b];
                end
            end
        endfunction

        // Greedy max over slots whose tag passes the lower bound
        function word_t best_xor(tag_t lower);
            word_t acc;
            acc = '0;
            for (int b = WORD_W - 1; b >= 0; b--) begin
                if (slot_word[b] != '0 && slot_tag[b] >= lower && !acc[b])
                    acc = acc ^ slot_word[b];
            end
            return acc;
        endfunction

        function void note_transfer(logic op, word_t word, tag_t tag, tag_t lower);
            if (op == OP_INSERT)
                insert_word(word, tag);
            else
                pending_max_xor.push_back(best_xor(lower));
        endfunction

        function void check_max_xor(word_t actual);
            word_t want;
            if (pending_max_xor.size() == 0) begin
                $display("%0t: max_xor %h arrived with no query outstanding", $time, actual);
                errors++;
            end else begin
                want = pending_max_xor.pop_front();
                if (actual !== want) begin
                    $display("%0t: max_xor mismatch, expected %h, actual %h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tsxb_in_if  #(.WORD_BITS(WORD_W), .INDEX_BITS(TAG_W)) in_ch ();
    tsxb_out_if #(.WORD_BITS(WORD_W))                     out_ch ();

    timestamped_xor_basis #(
        .WORD_BITS  (WORD_W),
        .INDEX_BITS (TAG_W)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    xor_basis_scoreboard sb;
    bit          no_gaps;
    bit          hold_req;
    int unsigned quiet_cycles;

    always #6 clk = ~clk;

    // Offer one item; valid is only lowered when a gap is drawn
    task automatic send_item(logic op, word_t word, tag_t tag, tag_t lower);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.value       <= word;
        in_ch.item_index  <= tag;
        in_ch.lower_index <= lower;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.note_transfer(op, word, tag, lower);
    endtask

    // Unused fields carry random values; the block must ignore them
    task automatic send_insert(word_t word, tag_t tag);
        send_item(OP_INSERT, word, tag, tag_t'($urandom));
    endtask

    task automatic send_query(tag_t lower);
        send_item(OP_QUERY, word_t'($urandom), tag_t'($urandom), lower);
    endtask

    task automatic wait_drained();
        while (sb.pending_max_xor.size() != 0) @(posedge clk);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
            sb.check_max_xor(out_ch.max_xor);
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        tag_t        cur_tag;
        tag_t        lower;
        word_t       word;
        int unsigned pick;
        int unsigned block;

        sb           = new();
        no_gaps      = 1'b0;
        hold_req     = 1'b0;
        quiet_cycles = 0;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_INSERT;
        in_ch.value       <= '0;
        in_ch.item_index  <= '0;
        in_ch.lower_index <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty basis, zero word, swaps, equal and older tags, filters
        send_query('0);
        send_insert('0, tag_t'(1));
        send_query('0);
        send_insert(20'hFFFFF, tag_t'(2));
        send_insert(20'h00001, tag_t'(3));
        send_insert(20'h80000, tag_t'(5));
        send_query('0);
        send_query(tag_t'(3));
        send_query(tag_t'(5));
        send_query(tag_t'(6));
        send_insert(20'h80001, tag_t'(5));
        send_insert(20'h40000, tag_t'(4));
        send_insert(20'h00003, tag_t'(1));
        send_query('0);
        send_query(tag_t'(2));
        send_query(20'hFFFFF);
        send_insert(20'h55555, tag_t'(8));
        send_insert(20'hAAAAA, tag_t'(9));
        send_query(tag_t'(7));
        send_query(tag_t'(9));
        cur_tag = tag_t'(10);

        // Random: mostly increasing tags, some noise with arbitrary tags
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0) begin
                block   = n / 50;
                no_gaps = (block == 2 || block == 7);
                if (block == 4) begin
                    // long receiver hold-off while queries keep coming
                    hold_req = 1'b1;
                    no_gaps  = 1'b1;
                    repeat (25) send_query(cur_tag - tag_t'($urandom_range(0, 30)));
                    no_gaps = 1'b0;
                end
                if (block == 6) begin
                    in_ch.valid <= 1'b0;
                    wait_drained();
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_insert(word_t'($urandom), tag_t'($urandom));
            end else if (pick < 58) begin
                if ($urandom_range(0, 39) == 0)
                    cur_tag = cur_tag + tag_t'($urandom_range(1000, 90000));
                else
                    cur_tag = cur_tag + tag_t'($urandom_range(1, 3));
                word = word_t'($urandom) >> $urandom_range(0, WORD_W - 1);
                if ($urandom_range(0, 19) == 0)
                    word = '0;
                send_insert(word, cur_tag);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    lower = '0;
                else if (pick == 1)
                    lower = tag_t'($urandom);
                else if (cur_tag > tag_t'(40))
                    lower = cur_tag - tag_t'($urandom_range(0, 40));
                else
                    lower = '0;
                send_query(lower);
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (2 * ITEM_CYC + 5) @(posedge clk);
        if (sb.errors == 0 && sb.pending_max_xor.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule : timestamped_xor_basis_test
